>>> hdl/srs_pkg.sv
// Shared types, codes and reset constants of the stepper ramp sequencer.
package srs_pkg;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_MOVE   = 2'd1,
      CMD_ROTATE = 2'd2,
      CMD_INIT   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_START_DELAY   = 3'd0,
      REG_QUARTER_STEPS = 3'd1,
      REG_RAMP_STEPS    = 3'd2,
      REG_RAMP_DELTA    = 3'd3,
      REG_MIN_DELAY     = 3'd4,
      REG_MAX_DELAY     = 3'd5
   } reg_index_type;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 11;

   // Coil drive patterns for phases 1 to 4.
   localparam logic [5:0] COIL_PHASE1 = 6'b000011;
   localparam logic [5:0] COIL_PHASE2 = 6'b011000;
   localparam logic [5:0] COIL_PHASE3 = 6'b000101;
   localparam logic [5:0] COIL_PHASE4 = 6'b101000;

   localparam logic [2:0] PHASE_FIRST = 3'd1;
   localparam logic [2:0] PHASE_LAST  = 3'd4;
   localparam logic [2:0] POS_FIRST   = 3'd1;
   localparam logic [2:0] POS_LAST    = 3'd4;

   localparam logic [7:0]  START_DELAY_RST   = 8'd20;
   localparam logic [10:0] QUARTER_STEPS_RST = 11'd50;
   localparam logic [7:0]  RAMP_STEPS_RST    = 8'd5;
   localparam logic [7:0]  RAMP_DELTA_RST    = 8'd2;
   localparam logic [7:0]  MIN_DELAY_RST     = 8'd10;
   localparam logic [7:0]  MAX_DELAY_RST     = 8'd20;

   typedef struct packed {
      logic [5:0] coil_pattern;
      logic       busy_res;
      logic       move_done;
      logic       rejected;
      logic [2:0] tray_position;
   } rsp_type;

endpackage

>>> hdl/stepper_ramp_sequencer_unit.sv
// Four-phase stepper sequencer with ramped step delay: top level.
// An accepted item's result goes into the output register, or into the skid entry.
// Throughput: one item per cycle while req_ready is up; all the per-item work is one
// pass of compares and adds between the state registers and the output register.
// A two-entry output (register plus skid) keeps req_ready up for one stalled result.
// Reset (synchronous, active high): registers to defaults, phase 1, position 1, idle.
module stepper_ramp_sequencer_unit
   import srs_pkg::*;
#(
   parameter int STEP_BITS  = 12,
   parameter int DELAY_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   // item input channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic [2:0]                req_target_position,
   input  logic [11:0]               req_step_count,
   input  logic                      req_direction,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [5:0]                rsp_coil_pattern,
   output logic                      rsp_busy_res,
   output logic                      rsp_move_done,
   output logic                      rsp_rejected,
   output logic [2:0]                rsp_tray_position
);

   // Compare widths: delays against the 8-bit registers, counts against 12-bit inputs.
   localparam int CW = (DELAY_BITS > 8) ? DELAY_BITS : 8;
   localparam int QW = (STEP_BITS > 12) ? STEP_BITS : 12;
   localparam logic [CW-1:0] DelayMaxExt = CW'({DELAY_BITS{1'b1}});
   localparam logic [QW-1:0] StepMaskExt = QW'({STEP_BITS{1'b1}});

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [7:0]  start_delay_ff, ramp_steps_ff, ramp_delta_ff, min_delay_ff, max_delay_ff;
   logic [10:0] quarter_steps_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_delay_ff   <= START_DELAY_RST;
         quarter_steps_ff <= QUARTER_STEPS_RST;
         ramp_steps_ff    <= RAMP_STEPS_RST;
         ramp_delta_ff    <= RAMP_DELTA_RST;
         min_delay_ff     <= MIN_DELAY_RST;
         max_delay_ff     <= MAX_DELAY_RST;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_START_DELAY:   start_delay_ff   <= csr_data[7:0];
            REG_QUARTER_STEPS: quarter_steps_ff <= csr_data;
            REG_RAMP_STEPS:    ramp_steps_ff    <= csr_data[7:0];
            REG_RAMP_DELTA:    ramp_delta_ff    <= csr_data[7:0];
            REG_MIN_DELAY:     min_delay_ff     <= csr_data[7:0];
            REG_MAX_DELAY:     max_delay_ff     <= csr_data[7:0];
            default: ;  // unused index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Motion state
   // ---------------------------------------------------------------
   logic [2:0]            phase_ff, phase_in;
   logic [2:0]            position_ff, position_in;
   logic [STEP_BITS-1:0]  steps_total_ff, steps_total_in;
   logic [STEP_BITS-1:0]  step_index_ff, step_index_in;
   logic [DELAY_BITS-1:0] cur_delay_ff, cur_delay_in;
   logic [DELAY_BITS-1:0] wait_left_ff, wait_left_in;
   logic                  move_dir_ff, move_dir_in;
   logic                  moving_ff, moving_in;

   // Output register and skid stage
   logic    rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_ff, skid_ff, result;

   logic req_accept;
   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;

   function automatic logic [2:0] next_phase(input logic [2:0] ph, input logic dir);
      logic [2:0] res;
      if (!dir) begin
         res = (ph >= PHASE_LAST) ? PHASE_FIRST : ph + 3'd1;
      end else begin
         res = (ph <= PHASE_FIRST) ? PHASE_LAST : ph - 3'd1;
      end
      return res;
   endfunction

   function automatic logic [DELAY_BITS-1:0] eff_delay(input logic [DELAY_BITS-1:0] d);
      return (d == '0) ? DELAY_BITS'(1) : d;
   endfunction

   // Start delay saturated to the delay counter's range.
   logic [CW-1:0]         start_ext;
   logic [DELAY_BITS-1:0] start_sat;
   assign start_ext = CW'(start_delay_ff);
   assign start_sat = (start_ext > DelayMaxExt) ? {DELAY_BITS{1'b1}}
                                                : start_ext[DELAY_BITS-1:0];

   // Step counts masked to STEP_BITS; the half turn saturates.
   logic [QW-1:0]        quarter_w, half_w, half_sat, rotate_w;
   logic [STEP_BITS-1:0] quarter_cnt, half_cnt, rotate_cnt;
   assign quarter_w   = QW'(quarter_steps_ff);
   assign half_w      = QW'({quarter_steps_ff, 1'b0});
   assign half_sat    = (half_w > StepMaskExt) ? StepMaskExt : half_w;
   assign rotate_w    = QW'(req_step_count);
   assign quarter_cnt = quarter_w[STEP_BITS-1:0];
   assign half_cnt    = half_sat[STEP_BITS-1:0];
   assign rotate_cnt  = rotate_w[STEP_BITS-1:0];

   // Ramp: accelerate in the first ramp_steps steps, then decelerate in the last ones.
   logic [CW-1:0]        cur_ext, delta_ext, after_dec, after_inc;
   logic [CW:0]          inc_sum;
   logic [STEP_BITS-1:0] ramp_ext, remain;
   logic                 dec_en, inc_en;
   logic [DELAY_BITS-1:0] ramped;

   assign cur_ext   = CW'(cur_delay_ff);
   assign delta_ext = CW'(ramp_delta_ff);
   assign ramp_ext  = STEP_BITS'(ramp_steps_ff);
   assign dec_en    = (step_index_ff < ramp_ext) && (cur_ext >= CW'(min_delay_ff));
   assign after_dec = !dec_en ? cur_ext
                    : (cur_ext >= delta_ext) ? cur_ext - delta_ext : '0;
   assign remain    = steps_total_ff - step_index_ff;
   assign inc_en    = (remain <= ramp_ext) && (after_dec <= CW'(max_delay_ff));
   assign inc_sum   = {1'b0, after_dec} + {1'b0, delta_ext};
   assign after_inc = (inc_sum > {1'b0, DelayMaxExt}) ? DelayMaxExt : inc_sum[CW-1:0];
   assign ramped    = inc_en ? after_inc[DELAY_BITS-1:0] : after_dec[DELAY_BITS-1:0];

   // Next state and result for the item at the input.
   cmd_type              cmd;
   logic [1:0]           fwd;
   logic                 start_req, start_dir;
   logic [STEP_BITS-1:0] start_cnt;
   logic [DELAY_BITS-1:0] wait_dec;
   logic [STEP_BITS-1:0] idx_inc;
   logic                 done, rej;
   logic [5:0]           coil;

   assign cmd = cmd_type'(req_command);
   // Quarter turns forward from the stored position, modulo four.
   assign fwd = req_target_position[1:0] - position_ff[1:0];

   always_comb begin
      phase_in       = phase_ff;
      position_in    = position_ff;
      steps_total_in = steps_total_ff;
      step_index_in  = step_index_ff;
      cur_delay_in   = cur_delay_ff;
      wait_left_in   = wait_left_ff;
      move_dir_in    = move_dir_ff;
      moving_in      = moving_ff;
      start_req      = 1'b0;
      start_cnt      = rotate_cnt;
      start_dir      = req_direction;
      done           = 1'b0;
      rej            = 1'b0;
      wait_dec       = (wait_left_ff != '0) ? wait_left_ff - DELAY_BITS'(1) : '0;
      idx_inc        = step_index_ff + STEP_BITS'(1);

      if (moving_ff) begin
         // Any command while busy is dropped but still counts as a tick.
         rej          = (cmd != CMD_TICK);
         wait_left_in = wait_dec;
         if (wait_dec == '0) begin
            cur_delay_in  = ramped;
            step_index_in = idx_inc;
            if (idx_inc >= steps_total_ff) begin
               moving_in = 1'b0;
               done      = 1'b1;
            end else begin
               phase_in     = next_phase(phase_ff, move_dir_ff);
               wait_left_in = eff_delay(ramped);
            end
         end
      end else begin
         unique case (cmd)
            CMD_INIT: begin
               phase_in    = PHASE_FIRST;
               position_in = POS_FIRST;
            end
            CMD_ROTATE: begin
               start_req = 1'b1;
            end
            CMD_MOVE: begin
               if (req_target_position >= POS_FIRST && req_target_position <= POS_LAST) begin
                  position_in = req_target_position;
                  unique case (fwd)
                     2'd1: begin
                        start_req = 1'b1;
                        start_cnt = quarter_cnt;
                        start_dir = 1'b0;
                     end
                     2'd3: begin
                        start_req = 1'b1;
                        start_cnt = quarter_cnt;
                        start_dir = 1'b1;
                     end
                     2'd2: begin
                        start_req = 1'b1;
                        start_cnt = half_cnt;
                        start_dir = 1'b0;
                     end
                     default: ;  // already there: no motion
                  endcase
               end
            end
            CMD_TICK: ;
         endcase

         // Start a move: take the first step on this same item.
         if (start_req && start_cnt != '0) begin
            steps_total_in = start_cnt;
            move_dir_in    = start_dir;
            step_index_in  = '0;
            cur_delay_in   = start_sat;
            moving_in      = 1'b1;
            phase_in       = next_phase(phase_ff, start_dir);
            wait_left_in   = eff_delay(start_sat);
         end
      end

      unique case (phase_in)
         3'd2:    coil = COIL_PHASE2;
         3'd3:    coil = COIL_PHASE3;
         3'd4:    coil = COIL_PHASE4;
         default: coil = COIL_PHASE1;
      endcase

      result.coil_pattern  = coil;
      result.busy_res      = moving_in;
      result.move_done     = done;
      result.rejected      = rej;
      result.tray_position = position_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_FIRST;
         position_ff    <= POS_FIRST;
         steps_total_ff <= '0;
         step_index_ff  <= '0;
         cur_delay_ff   <= start_sat;
         wait_left_ff   <= '0;
         move_dir_ff    <= 1'b0;
         moving_ff      <= 1'b0;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         position_ff    <= position_in;
         steps_total_ff <= steps_total_in;
         step_index_ff  <= step_index_in;
         cur_delay_ff   <= cur_delay_in;
         wait_left_ff   <= wait_left_in;
         move_dir_ff    <= move_dir_in;
         moving_ff      <= moving_in;
      end
   end

   // Output register with one skid entry: park a new result while the old one stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && !rsp_ready) begin
         if (req_accept) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && !rsp_ready) begin
         if (req_accept) begin
            skid_ff <= result;
         end
      end else if (skid_valid_ff) begin
         rsp_ff <= skid_ff;
      end else if (req_accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_coil_pattern  = rsp_ff.coil_pattern;
   assign rsp_busy_res      = rsp_ff.busy_res;
   assign rsp_move_done     = rsp_ff.move_done;
   assign rsp_rejected      = rsp_ff.rejected;
   assign rsp_tray_position = rsp_ff.tray_position;

`ifndef NO_ASSERTIONS
   // A parked result always has an older result ahead of it.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid with empty output register");

   // A running move always has a pending wait.
   a_wait_while_moving: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (wait_left_ff != '0))
      else $error("moving with no wait pending");

   // A running move has steps left.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (step_index_ff < steps_total_ff))
      else $error("step index past total while moving");

   // A finishing item reports the block idle.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.move_done) |-> !rsp_ff.busy_res)
      else $error("move_done reported with busy set");

   // The phase stays within 1 to 4.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff >= PHASE_FIRST) && (phase_ff <= PHASE_LAST))
      else $error("phase out of range");
`endif

endmodule
